[src/cte_pkg.sv]
package cte_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam int ACTION_W   = 3;
    localparam int USER_W     = 16;
    localparam int PW_W       = 32;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = USER_W + PW_W;
    localparam int S_TDATA_W  = 56;  // 55 bits of fields, padded to bytes
    localparam int M_TDATA_W  = 8;   // 6 bits of fields, padded to bytes

    localparam logic [7:0]         FREE_BYTE  = 8'h2D;
    localparam logic [USER_W-1:0]  FREE_USER  = {2{FREE_BYTE}};
    localparam logic [ENTRY_W-1:0] FREE_ENTRY = {6{FREE_BYTE}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIND_USER = 3'd0,
        ACT_FIND_PW   = 3'd1,
        ACT_ADD       = 3'd2,
        ACT_CHANGE_PW = 3'd3,
        ACT_ERASE     = 3'd4,
        ACT_CLEAR     = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WRITE,
        S_PUSH
    } state_t;

endpackage

[src/cte_ram.sv]
module cte_ram
    import cte_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = DEF_ENTRIES
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/credential_table_engine.sv]
// Flow, accept to result beat: find user / find password / add entry scan the table from entry 0
// and stop at the first hit or after the last entry (one entry per cycle through the RAM port);
// change password does a read-modify-write of one entry; erase, clear all and bad codes go straight to the result.
// One request at a time; the next is taken once the result has moved to the output register.
// Reset (aresetn low, synchronous) clears the per-entry valid flags, so the whole table
// reads as free ('-' bytes) at once; there is no clearing pass.
module credential_table_engine
    import cte_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action, user_code, password, slot
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, slot_found
);

    localparam int IDX_W = $clog2(ENTRIES);

    state_t state_reg, state_next;

    action_t           act_reg;
    logic [USER_W-1:0] user_reg;
    logic [PW_W-1:0]   pw_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [IDX_W:0]   scan_cnt_reg, scan_cnt_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_free_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // input beat fields
    logic [ACTION_W-1:0] in_action;
    logic [USER_W-1:0]   in_user;
    logic [PW_W-1:0]     in_pw;
    logic [SLOT_W-1:0]   in_slot;
    logic                in_slot_ok;
    logic                accept;
    logic                out_free;

    // RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ENTRY_W-1:0] entry;
    logic               hit;
    logic               scan_hit;
    logic               scan_miss;
    logic               slot_ok_reg;

    logic                vld_set;
    logic                vld_clr_one;
    logic                vld_clr_all;
    logic [IDX_W-1:0]    vld_idx;
    logic                res_load;
    logic [STATUS_W-1:0] res_status_val;
    logic [SLOT_W-1:0]   res_slot_val;

    assign in_action  = s_tdata[2:0];
    assign in_user    = s_tdata[18:3];
    assign in_pw      = s_tdata[50:19];
    assign in_slot    = s_tdata[54:51];
    assign in_slot_ok = 32'(in_slot) < ENTRIES;
    assign slot_ok_reg = 32'(slot_reg) < ENTRIES;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    cte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // compare stage: entries never written since reset/clear/erase read as free
    assign entry = rd_free_reg ? FREE_ENTRY : ram_rdata;

    always_comb begin
        case (act_reg)
            ACT_FIND_USER: hit = (entry[ENTRY_W-1:PW_W] == user_reg);
            ACT_FIND_PW:   hit = (entry[PW_W-1:0] == pw_reg);
            ACT_ADD:       hit = (entry[ENTRY_W-1:ENTRY_W-8] == FREE_BYTE);
            default:       hit = 1'b0;
        endcase
    end

    assign scan_hit  = (state_reg == S_SCAN) && rd_vld_reg && hit;
    assign scan_miss = (state_reg == S_SCAN) && rd_vld_reg && !hit
                       && (rd_idx_reg == IDX_W'(ENTRIES - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_action inside {ACT_FIND_USER, ACT_FIND_PW, ACT_ADD}) begin
                        state_next = S_SCAN;
                    end else if (in_action == ACT_CHANGE_PW && in_slot_ok) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    state_next = S_PUSH;
                end
            end
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_PUSH;
            S_PUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs: RAM control, valid flags, result
    always_comb begin
        ram_we         = 1'b0;
        ram_waddr      = rd_idx_reg;
        ram_wdata      = {user_reg, pw_reg};
        ram_re         = 1'b0;
        ram_raddr      = scan_cnt_reg[IDX_W-1:0];
        scan_cnt_next  = scan_cnt_reg;
        vld_set        = 1'b0;
        vld_clr_one    = 1'b0;
        vld_clr_all    = 1'b0;
        vld_idx        = rd_idx_reg;
        res_load       = 1'b0;
        res_status_val = ST_NOT_FOUND;
        res_slot_val   = '0;
        case (state_reg)
            S_IDLE: begin
                scan_cnt_next = '0;
                if (accept) begin
                    res_load = 1'b1;
                    case (in_action)
                        ACT_ERASE: begin
                            if (in_slot_ok) begin
                                vld_clr_one    = 1'b1;
                                vld_idx        = IDX_W'(in_slot);
                                res_status_val = ST_OK;
                                res_slot_val   = in_slot;
                            end
                        end
                        ACT_CLEAR: begin
                            vld_clr_all    = 1'b1;
                            res_status_val = ST_OK;
                        end
                        default: begin
                            res_status_val = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_cnt_reg < (IDX_W+1)'(ENTRIES) && !scan_hit) begin
                    ram_re        = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (scan_hit) begin
                    res_load       = 1'b1;
                    res_status_val = ST_OK;
                    res_slot_val   = SLOT_W'(rd_idx_reg);
                    if (act_reg == ACT_ADD) begin
                        ram_we  = 1'b1;
                        vld_set = 1'b1;
                    end
                end else if (scan_miss) begin
                    res_load       = 1'b1;
                    res_status_val = (act_reg == ACT_ADD) ? ST_FULL : ST_NOT_FOUND;
                end
            end
            S_READ: begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(slot_reg);
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(slot_reg);
                ram_wdata = {(rd_free_reg ? FREE_USER : ram_rdata[ENTRY_W-1:PW_W]), pw_reg};
                vld_set   = 1'b1;
                vld_idx   = IDX_W'(slot_reg);
                res_load       = 1'b1;
                res_status_val = slot_ok_reg ? ST_OK : ST_NOT_FOUND;
                res_slot_val   = slot_ok_reg ? slot_reg : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= ram_re && (state_reg == S_SCAN);
            if (vld_clr_all) begin
                valid_reg <= '0;
            end else if (vld_clr_one) begin
                valid_reg[vld_idx] <= 1'b0;
            end else if (vld_set) begin
                valid_reg[vld_idx] <= 1'b1;
            end
            if (state_reg == S_PUSH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg <= scan_cnt_next;
        if (accept) begin
            act_reg  <= action_t'(in_action);
            user_reg <= in_user;
            pw_reg   <= in_pw;
            slot_reg <= in_slot;
        end
        if (ram_re) begin
            rd_idx_reg  <= ram_raddr;
            rd_free_reg <= !valid_reg[ram_raddr];
        end
        if (res_load) begin
            res_status_reg <= res_status_val;
            res_slot_reg   <= res_slot_val;
        end
        if (state_reg == S_PUSH && out_free) begin
            m_tdata_reg <= {2'b00, res_slot_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/credential_table_checker.sv]
module credential_table_checker
    import cte_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action, user_code, password, slot
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // status, slot_found
    output int                   err_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } answer_t;

    logic [ENTRY_W-1:0] cred_store [ENTRIES];
    answer_t            expected_answers [$];

    // Applies one request to the local copy of the table and returns its answer.
    function automatic answer_t apply_request(logic [ACTION_W-1:0] act,
                                              logic [USER_W-1:0]   user,
                                              logic [PW_W-1:0]     pw,
                                              logic [SLOT_W-1:0]   slot);
        answer_t ans;
        ans.status = ST_NOT_FOUND;
        ans.slot   = '0;
        case (act)
            ACT_FIND_USER: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (cred_store[i][ENTRY_W-1 -: USER_W] == user) begin
                        ans.status = ST_OK;
                        ans.slot   = SLOT_W'(i);
                        break;
                    end
                end
            end
            ACT_FIND_PW: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (cred_store[i][PW_W-1:0] == pw) begin
                        ans.status = ST_OK;
                        ans.slot   = SLOT_W'(i);
                        break;
                    end
                end
            end
            ACT_ADD: begin
                ans.status = ST_FULL;
                // free means first user byte is '-', whatever the rest holds
                for (int i = 0; i < ENTRIES; i++) begin
                    if (cred_store[i][ENTRY_W-1 -: 8] == FREE_BYTE) begin
                        cred_store[i] = {user, pw};
                        ans.status    = ST_OK;
                        ans.slot      = SLOT_W'(i);
                        break;
                    end
                end
            end
            ACT_CHANGE_PW: begin
                if (slot < ENTRIES) begin
                    cred_store[slot][PW_W-1:0] = pw;
                    ans.status = ST_OK;
                    ans.slot   = slot;
                end
            end
            ACT_ERASE: begin
                if (slot < ENTRIES) begin
                    cred_store[slot] = FREE_ENTRY;
                    ans.status = ST_OK;
                    ans.slot   = slot;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++)
                    cred_store[i] = FREE_ENTRY;
                ans.status = ST_OK;
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++)
                cred_store[i] = FREE_ENTRY;
            expected_answers.delete();
        end else begin
            // result first: a new request can be taken on the same edge
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[STATUS_W-1:0];
                got.slot   = m_tdata[STATUS_W +: SLOT_W];
                if (expected_answers.size() == 0) begin
                    $error("result beat with no request outstanding: status %0d slot_found %0d",
                           got.status, got.slot);
                    err_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_count++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot_found: expected %0d, got %0d", want.slot, got.slot);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_answers.push_back(apply_request(
                    s_tdata[ACTION_W-1:0],
                    s_tdata[ACTION_W +: USER_W],
                    s_tdata[ACTION_W+USER_W +: PW_W],
                    s_tdata[ACTION_W+USER_W+PW_W +: SLOT_W]));
        end
        pending = expected_answers.size();
    end

endmodule

[tb/credential_table_engine_tb.sv]
module credential_table_engine_tb;
    import cte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = DEF_ENTRIES;
    localparam int RAND_ITEMS = 1830;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   err_count;
    int                   pending;

    bit                   quiet = 1'b0;   // no idling on either side while set
    logic [USER_W-1:0]    user_pool [6];
    logic [PW_W-1:0]      pw_pool [6];

    always #2 aclk = ~aclk;

    credential_table_engine #(.ENTRIES(ENTRIES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    credential_table_checker #(.ENTRIES(ENTRIES)) chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .err_count (err_count),
        .pending   (pending)
    );

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(logic [ACTION_W-1:0] act, logic [USER_W-1:0] user,
                                logic [PW_W-1:0] pw, logic [SLOT_W-1:0] slot);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, slot, pw, user, act};
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        @(negedge aclk);
    endtask

    // Mostly codes already in play, so finds hit and '-' bytes show up often.
    function automatic logic [USER_W-1:0] pick_user();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return user_pool[r];
        else if (r == 6)
            return FREE_USER;
        else if (r == 7)
            return {FREE_BYTE, 8'($urandom)};
        return USER_W'($urandom);
    endfunction

    function automatic logic [PW_W-1:0] pick_pw();
        int r;
        r = $urandom_range(0, 8);
        if (r < 6)
            return pw_pool[r];
        else if (r == 6)
            return {2{FREE_USER}};
        return $urandom;
    endfunction

    task automatic send_random();
        int r;
        logic [ACTION_W-1:0] act;
        r = $urandom_range(0, 99);
        if (r < 20)
            act = ACT_FIND_USER;
        else if (r < 35)
            act = ACT_FIND_PW;
        else if (r < 64)
            act = ACT_ADD;
        else if (r < 78)
            act = ACT_CHANGE_PW;
        else if (r < 92)
            act = ACT_ERASE;
        else if (r < 95)
            act = ACT_CLEAR;
        else
            act = ACTION_W'($urandom_range(6, 7));
        send_request(act, pick_user(), pick_pw(), SLOT_W'($urandom));
    endtask

    // receiving side
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_tvalid)
                    break;
            end
            @(negedge aclk);
        end
    end

    initial begin
        int sent;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int i = 0; i < 6; i++) begin
            user_pool[i] = USER_W'($urandom);
            pw_pool[i]   = $urandom;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty table matches '-' bytes
        send_request(ACT_FIND_USER, FREE_USER, '0, '0);
        send_request(ACT_FIND_PW, '0, {2{FREE_USER}}, '0);
        send_request(ACT_FIND_USER, '0, '0, '0);
        send_request(ACT_FIND_PW, '0, '1, '0);
        send_request(ACT_ADD, '1, '1, '0);
        send_request(ACT_ADD, '0, '0, '1);
        send_request(ACT_FIND_USER, '1, '0, '0);
        send_request(ACT_FIND_PW, '0, '0, '0);
        send_request(ACT_CHANGE_PW, '0, 32'hA5A5_5A5A, 4'd15);
        send_request(ACT_FIND_PW, '0, 32'hA5A5_5A5A, '0);
        // user starting with '-' leaves the entry looking free
        send_request(ACT_ADD, {FREE_BYTE, 8'h41}, 32'h1, '0);
        send_request(ACT_ADD, 16'h1234, 32'h2, '0);
        send_request(ACT_ERASE, '0, '0, 4'd0);
        send_request(ACT_FIND_USER, '1, '0, '0);
        send_request(ACTION_W'(6), '0, '0, '0);
        send_request(ACTION_W'(7), '1, '1, '1);
        send_request(ACT_ERASE, '0, '0, 4'd15);
        send_request(ACT_CLEAR, '0, '0, '0);
        send_request(ACT_FIND_USER, '0, '0, '0);

        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 59) == 0) begin
                // fill the table and run past its end
                send_request(ACT_CLEAR, '0, '0, '0);
                for (int i = 0; i <= ENTRIES; i++)
                    send_request(ACT_ADD, pick_user(), pick_pw(), SLOT_W'($urandom));
                send_request(ACT_FIND_PW, '0, pick_pw(), '0);
                sent += ENTRIES + 3;
            end else begin
                send_random();
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge aclk);
        repeat (ENTRIES + 4) @(negedge aclk);
        if (err_count == 0)
            $display("credential_table_engine_tb: done, clean");
        else
            $display("credential_table_engine_tb: done, errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("credential_table_engine_tb: done, errors");
        $finish;
    end

endmodule
